>>> rtl/dlle_pkg.sv
package dlle_pkg;

  localparam int MAX_NODES  = 63;
  localparam int HANDLE_W   = 6;
  localparam int POOL_DEPTH = 1 << HANDLE_W;
  localparam int CNT_W      = 7;
  localparam int VALUE_W    = 32;
  localparam int MODE_W     = 3;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = 1;

  localparam logic [MODE_W-1:0] MODE_INS_AFTER  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_BEFORE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE      = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DUMP       = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR      = 3'd4;

  typedef enum logic [2:0] {
    OP_INS_AFTER,
    OP_INS_BEFORE,
    OP_ERASE,
    OP_DUMP,
    OP_CLEAR,
    OP_REJECT
  } op_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_INS_WR1,
    BS_INS_WR2,
    BS_ERASE,
    BS_DUMP
  } bstate_t;

  typedef struct packed {
    op_t                        op;
    logic [HANDLE_W-1:0]        handle;
    logic signed [VALUE_W-1:0]  value;
    logic [HANDLE_W-1:0]        new_handle;
  } cmd_t;

  typedef struct packed {
    logic push;
    cmd_t cmd;
  } qwr_t;

  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } qrd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] result_value;
    logic [HANDLE_W-1:0]       new_handle;
    logic                      has_value;
    logic                      error;
    logic                      last;
  } res_t;

endpackage

>>> rtl/dlle_if.sv
interface dlle_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [dlle_pkg::MODE_W-1:0]          mode;
  logic [dlle_pkg::HANDLE_W-1:0]        handle;
  logic signed [dlle_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output mode, output handle, output value, input ready);
  modport sink   (input valid, input mode, input handle, input value, output ready);
endinterface

interface dlle_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dlle_pkg::VALUE_W-1:0]  result_value;
  logic [dlle_pkg::HANDLE_W-1:0]        new_handle;
  logic                                 has_value;
  logic                                 error;
  logic                                 last;

  modport source (output valid, output result_value, output new_handle, output has_value,
                  output error, output last, input ready);
  modport sink   (input valid, input result_value, input new_handle, input has_value,
                  input error, input last, output ready);
endinterface

>>> rtl/dlle_front.sv
module dlle_front (
  input  logic          clk,
  input  logic          rst_n,
  dlle_in_if.sink       in_ch,
  input  logic          q_full,
  output dlle_pkg::qwr_t q_wr
);
  import dlle_pkg::*;

  logic [CNT_W-1:0] alloc_cnt_r;
  logic [CNT_W-1:0] alloc_cnt_nxt;
  logic             ins_ok;
  logic             erase_ok;
  logic             accept;
  cmd_t             cmd;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  // allocation is a pure function of the command stream, so track it here
  always_comb begin
    ins_ok   = (alloc_cnt_r <= CNT_W'(MAX_NODES)) && ({1'b0, in_ch.handle} < alloc_cnt_r);
    erase_ok = (in_ch.handle != '0) && ({1'b0, in_ch.handle} < alloc_cnt_r);
    cmd.handle     = in_ch.handle;
    cmd.value      = in_ch.value;
    cmd.new_handle = alloc_cnt_r[HANDLE_W-1:0];
    cmd.op         = OP_REJECT;
    alloc_cnt_nxt  = alloc_cnt_r;
    unique case (in_ch.mode)
      MODE_INS_AFTER: begin
        if (ins_ok) begin
          cmd.op        = OP_INS_AFTER;
          alloc_cnt_nxt = alloc_cnt_r + CNT_W'(1);
        end
      end
      MODE_INS_BEFORE: begin
        if (ins_ok) begin
          cmd.op        = OP_INS_BEFORE;
          alloc_cnt_nxt = alloc_cnt_r + CNT_W'(1);
        end
      end
      MODE_ERASE: begin
        if (erase_ok) cmd.op = OP_ERASE;
      end
      MODE_DUMP: begin
        cmd.op = OP_DUMP;
      end
      MODE_CLEAR: begin
        cmd.op        = OP_CLEAR;
        alloc_cnt_nxt = CNT_W'(1);
      end
      default: begin
        cmd.op = OP_REJECT;
      end
    endcase
  end

  assign q_wr.push = accept;
  assign q_wr.cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_cnt_r <= CNT_W'(1);
    end else if (accept) begin
      alloc_cnt_r <= alloc_cnt_nxt;
    end
  end

endmodule

>>> rtl/dlle_queue.sv
module dlle_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  dlle_pkg::qwr_t q_wr,
  output logic           q_full,
  output dlle_pkg::qrd_t q_rd,
  input  logic           q_pop
);
  import dlle_pkg::*;

  cmd_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;
  logic              do_push;
  logic              do_pop;

  assign q_full     = (count_r == (QPTR_W+1)'(QDEPTH));
  assign q_rd.avail = (count_r != '0);
  assign q_rd.cmd   = slot_r[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.avail;

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= q_wr.cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_r + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

endmodule

>>> rtl/dlle_back.sv
module dlle_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dlle_pkg::qrd_t q_rd,
  output logic           q_pop,
  dlle_out_if.source     out_ch
);
  import dlle_pkg::*;

  localparam logic [HANDLE_W-1:0] DUMP_LAST = HANDLE_W'(MAX_NODES - 1);

  // link and value pools; entry 0 of the link pools lives in head_*_r
  logic [HANDLE_W-1:0] next_mem [POOL_DEPTH];
  logic [HANDLE_W-1:0] prev_mem [POOL_DEPTH];
  logic [VALUE_W-1:0]  val_mem  [POOL_DEPTH];

  logic [HANDLE_W-1:0] head_next_r;
  logic [HANDLE_W-1:0] head_prev_r;
  logic [HANDLE_W-1:0] rd_next_r;
  logic [HANDLE_W-1:0] rd_prev_r;
  logic [VALUE_W-1:0]  rd_val_r;
  logic                rd_zero_r;

  bstate_t             state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [HANDLE_W-1:0] cnt_r, cnt_nxt;
  logic                out_valid_r;
  res_t                out_res_r;

  logic                rd_en;
  logic [HANDLE_W-1:0] rd_addr;
  logic                wn_en, wp_en, wv_en;
  logic [HANDLE_W-1:0] wn_addr, wn_data, wp_addr, wp_data, wv_addr;
  logic                head_clr;
  logic                load_out;
  res_t                res;
  logic                out_free;
  logic [HANDLE_W-1:0] link_next, link_prev, link, node_a, node_b;
  logic                dump_last;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign link_next = rd_zero_r ? head_next_r : rd_next_r;
  assign link_prev = rd_zero_r ? head_prev_r : rd_prev_r;

  always_comb begin
    link   = (cmd_r.op == OP_INS_AFTER) ? link_next : link_prev;
    node_a = (cmd_r.op == OP_INS_AFTER) ? cmd_r.handle : link;
    node_b = (cmd_r.op == OP_INS_AFTER) ? link : cmd_r.handle;
    dump_last = (link_next == '0) || (cnt_r == DUMP_LAST);
  end

  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = q_rd.cmd.handle;
    wn_en     = 1'b0;
    wn_addr   = '0;
    wn_data   = '0;
    wp_en     = 1'b0;
    wp_addr   = '0;
    wp_data   = '0;
    wv_en     = 1'b0;
    wv_addr   = cmd_r.new_handle;
    head_clr  = 1'b0;
    load_out  = 1'b0;
    res       = '0;
    res.last  = 1'b1;
    unique case (state_r)
      BS_IDLE: begin
        if (q_rd.avail) begin
          unique case (q_rd.cmd.op) inside
            OP_INS_AFTER, OP_INS_BEFORE: begin
              q_pop     = 1'b1;
              rd_en     = 1'b1;
              cmd_nxt   = q_rd.cmd;
              state_nxt = BS_INS_WR1;
            end
            OP_ERASE: begin
              q_pop     = 1'b1;
              rd_en     = 1'b1;
              cmd_nxt   = q_rd.cmd;
              state_nxt = BS_ERASE;
            end
            OP_DUMP: begin
              if (head_next_r != '0) begin
                q_pop     = 1'b1;
                rd_en     = 1'b1;
                rd_addr   = head_next_r;
                cnt_nxt   = '0;
                state_nxt = BS_DUMP;
              end else if (out_free) begin
                // empty list: one beat with no value
                q_pop    = 1'b1;
                load_out = 1'b1;
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                q_pop    = 1'b1;
                head_clr = 1'b1;
                load_out = 1'b1;
              end
            end
            default: begin
              if (out_free) begin
                q_pop     = 1'b1;
                load_out  = 1'b1;
                res.error = 1'b1;
              end
            end
          endcase
        end
      end
      BS_INS_WR1: begin
        wn_en     = 1'b1;
        wn_addr   = cmd_r.new_handle;
        wn_data   = node_b;
        wp_en     = 1'b1;
        wp_addr   = cmd_r.new_handle;
        wp_data   = node_a;
        wv_en     = 1'b1;
        state_nxt = BS_INS_WR2;
      end
      BS_INS_WR2: begin
        // hold the splice until the result beat can go, so it fires once
        if (out_free) begin
          wp_en          = 1'b1;
          wp_addr        = node_b;
          wp_data        = cmd_r.new_handle;
          wn_en          = 1'b1;
          wn_addr        = node_a;
          wn_data        = cmd_r.new_handle;
          load_out       = 1'b1;
          res.new_handle = cmd_r.new_handle;
          state_nxt      = BS_IDLE;
        end
      end
      BS_ERASE: begin
        if (out_free) begin
          wn_en            = 1'b1;
          wn_addr          = link_prev;
          wn_data          = link_next;
          wp_en            = 1'b1;
          wp_addr          = link_next;
          wp_data          = link_prev;
          load_out         = 1'b1;
          res.result_value = rd_val_r;
          res.has_value    = 1'b1;
          state_nxt        = BS_IDLE;
        end
      end
      BS_DUMP: begin
        if (out_free) begin
          load_out         = 1'b1;
          res.result_value = rd_val_r;
          res.has_value    = 1'b1;
          res.last         = dump_last;
          if (dump_last) begin
            state_nxt = BS_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = link_next;
            cnt_nxt = cnt_r + HANDLE_W'(1);
          end
        end
      end
      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wn_en && wn_addr != '0) next_mem[wn_addr] <= wn_data;
    if (wp_en && wp_addr != '0) prev_mem[wp_addr] <= wp_data;
    if (wv_en) val_mem[wv_addr] <= cmd_r.value;
    if (rd_en) begin
      rd_next_r <= next_mem[rd_addr];
      rd_prev_r <= prev_mem[rd_addr];
      rd_val_r  <= val_mem[rd_addr];
      rd_zero_r <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_next_r <= '0;
      head_prev_r <= '0;
    end else if (head_clr) begin
      head_next_r <= '0;
      head_prev_r <= '0;
    end else begin
      if (wn_en && wn_addr == '0) head_next_r <= wn_data;
      if (wp_en && wp_addr == '0) head_prev_r <= wp_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    cnt_r <= cnt_nxt;
    if (load_out) out_res_r <= res;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_res_r.result_value;
  assign out_ch.new_handle   = out_res_r.new_handle;
  assign out_ch.has_value    = out_res_r.has_value;
  assign out_ch.error        = out_res_r.error;
  assign out_ch.last         = out_res_r.last;

endmodule

>>> rtl/doubly_linked_list_engine_unit.sv
// Channel  Dir  Handshake     Payload
// in_ch    in   valid/ready   mode[2:0], handle[5:0], value[31:0] signed
// out_ch   out  valid/ready   result_value[31:0] signed, new_handle[5:0],
//                             has_value, error, last
//
// Each link pool has a single write port, so an insert writes the new node's links in
// BS_INS_WR1 and splices its neighbours in BS_INS_WR2; a dump gives one beat per element.
// A two-entry queue lets the front take beats while the back works.
// Reset (synchronous, rst_n low) empties the list; no clearing pass is needed.
// out_ch stalls hold the result register and halt the back end where it
// emits a beat; in_ch stalls only once the queue is full.
module doubly_linked_list_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  dlle_in_if.sink    in_ch,
  dlle_out_if.source out_ch
);
  import dlle_pkg::*;

  qwr_t q_wr;
  qrd_t q_rd;
  logic q_full;
  logic q_pop;

  dlle_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  dlle_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  dlle_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

>>> rtl/dlle_checker.sv
module dlle_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result_value,
  input logic [5:0]  out_new_handle,
  input logic        out_has_value,
  input logic        out_error,
  input logic        out_last
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) &&
      $stable(out_new_handle) && $stable(out_last))
    else $error("result beat changed while stalled");

  // a refused request carries nothing else and ends the item
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> !out_has_value && out_new_handle == 6'd0 && out_last)
    else $error("error beat carries payload");

  // an insert result is a single final beat without value
  a_ins_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_new_handle != 6'd0 |-> out_last && !out_has_value && !out_error)
    else $error("insert beat malformed");

  // beats without a value show zero
  a_novalue_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_value |-> out_result_value == 32'd0)
    else $error("value shown on a beat without one");

endmodule

bind doubly_linked_list_engine_unit dlle_checker u_dlle_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_value (out_ch.result_value),
  .out_new_handle   (out_ch.new_handle),
  .out_has_value    (out_ch.has_value),
  .out_error        (out_ch.error),
  .out_last         (out_ch.last)
);

>>> tb/sv/tb_doubly_linked_list_engine_unit.sv
module tb_doubly_linked_list_engine_unit;
  import dlle_pkg::*;

  localparam logic [MODE_W-1:0] MODE_TOP = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * POOL_DEPTH;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int HOLDOFF_AT     = 40;
  localparam int RANDOM_ITEMS   = 150;

  typedef struct packed {
    logic [MODE_W-1:0]         mode;
    logic [HANDLE_W-1:0]       handle;
    logic signed [VALUE_W-1:0] value;
  } list_cmd_t;

  logic clk = 1'b0;
  logic rst_n;

  dlle_in_if  in_ch ();
  dlle_out_if out_ch ();

  doubly_linked_list_engine_unit u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow list: links, stored values and the next free handle
  logic [HANDLE_W-1:0]       link_next [POOL_DEPTH];
  logic [HANDLE_W-1:0]       link_prev [POOL_DEPTH];
  logic signed [VALUE_W-1:0] node_val  [POOL_DEPTH];
  logic [CNT_W-1:0]          next_free;

  res_t      expected_results [$];
  list_cmd_t cmd_backlog [$];

  int gen_free;
  int fail_cnt;
  int in_beats;
  int idle_cycles;
  bit in_taken;
  int burst_left;
  int gap_left;
  int phase_cycles;
  int stall_style;
  int holdoff_left;
  bit holdoff_done;

  task automatic clear_list();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      link_next[i] = '0;
      link_prev[i] = '0;
      node_val[i]  = '0;
    end
    next_free = CNT_W'(1);
  endtask

  task automatic apply_list_op(input logic [MODE_W-1:0] m, input logic [HANDLE_W-1:0] h,
                               input logic signed [VALUE_W-1:0] v);
    logic [HANDLE_W-1:0] n, a, b, nx, pv, cur, cur_next;
    int   cnt;
    res_t res;
    res = '0;
    res.last = 1'b1;
    case (m)
      MODE_INS_AFTER, MODE_INS_BEFORE: begin
        if (next_free > MAX_NODES || {1'b0, h} >= next_free) begin
          res.error = 1'b1;
        end else begin
          n = next_free[HANDLE_W-1:0];
          if (m == MODE_INS_AFTER) begin
            a = h;
            b = link_next[h];
          end else begin
            a = link_prev[h];
            b = h;
          end
          node_val[n]  = v;
          link_next[n] = b;
          link_prev[n] = a;
          link_prev[b] = n;
          link_next[a] = n;
          next_free    = next_free + 1'b1;
          res.new_handle = n;
        end
        expected_results.push_back(res);
      end
      MODE_ERASE: begin
        if (h == '0 || {1'b0, h} >= next_free) begin
          res.error = 1'b1;
        end else begin
          // erased nodes keep their links, so a second erase relinks from them
          nx = link_next[h];
          pv = link_prev[h];
          link_next[pv] = nx;
          link_prev[nx] = pv;
          res.result_value = node_val[h];
          res.has_value    = 1'b1;
        end
        expected_results.push_back(res);
      end
      MODE_DUMP: begin
        cur = link_next[0];
        cnt = 0;
        if (cur == '0) expected_results.push_back(res);
        // stop after MAX_NODES values even if the links loop
        while (cur != '0 && cnt < MAX_NODES) begin
          cur_next = link_next[cur];
          cnt++;
          res = '0;
          res.result_value = node_val[cur];
          res.has_value    = 1'b1;
          res.last         = (cur_next == '0) || (cnt == MAX_NODES);
          expected_results.push_back(res);
          cur = cur_next;
        end
      end
      MODE_CLEAR: begin
        clear_list();
        expected_results.push_back(res);
      end
      default: begin
        res.error = 1'b1;
        expected_results.push_back(res);
      end
    endcase
  endtask

  // Queue a command and track the allocation count it leads to
  task automatic queue_cmd(input logic [MODE_W-1:0] m, input int h,
                           input logic [VALUE_W-1:0] v);
    list_cmd_t c;
    c.mode   = m;
    c.handle = h[HANDLE_W-1:0];
    c.value  = v;
    cmd_backlog.push_back(c);
    if ((m == MODE_INS_AFTER || m == MODE_INS_BEFORE) && gen_free <= MAX_NODES
        && (h % POOL_DEPTH) < gen_free) begin
      gen_free++;
    end else if (m == MODE_CLEAR) begin
      gen_free = 1;
    end
  endtask

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic gen_sequence(input bit fill_pool);
    int len;
    int pick;
    logic [MODE_W-1:0] m;
    if (fill_pool) begin
      while (gen_free <= MAX_NODES) begin
        m = $urandom_range(0, 1) ? MODE_INS_AFTER : MODE_INS_BEFORE;
        queue_cmd(m, $urandom_range(0, gen_free - 1), rand_value());
      end
      // pool exhausted: both inserts must be refused
      queue_cmd(MODE_INS_AFTER, 0, rand_value());
      queue_cmd(MODE_INS_BEFORE, $urandom_range(0, POOL_DEPTH - 1), rand_value());
      queue_cmd(MODE_DUMP, 0, rand_value());
      repeat (3) queue_cmd(MODE_ERASE, $urandom_range(1, MAX_NODES), rand_value());
      queue_cmd(MODE_DUMP, $urandom_range(0, POOL_DEPTH - 1), rand_value());
      queue_cmd(MODE_CLEAR, 0, rand_value());
    end else begin
      len = $urandom_range(5, 15);
      repeat (len) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          m = $urandom_range(0, 1) ? MODE_INS_AFTER : MODE_INS_BEFORE;
          queue_cmd(m, $urandom_range(0, gen_free - 1), rand_value());
        end else if (pick < 75 && gen_free > 1) begin
          queue_cmd(MODE_ERASE, $urandom_range(1, gen_free - 1), rand_value());
        end else if (pick < 88) begin
          queue_cmd(MODE_DUMP, $urandom_range(0, POOL_DEPTH - 1), rand_value());
        end else begin
          queue_cmd(MODE_W'($urandom_range(0, MODE_TOP)), $urandom_range(0, POOL_DEPTH - 1),
                    $urandom);
        end
      end
      queue_cmd(MODE_DUMP, $urandom_range(0, POOL_DEPTH - 1), rand_value());
      if (gen_free > 40 || $urandom_range(0, 3) == 0) begin
        queue_cmd(MODE_CLEAR, $urandom_range(0, POOL_DEPTH - 1), rand_value());
      end
    end
  endtask

  // Driver: offer backlog beats in bursts, change inputs on the falling edge
  always @(negedge clk) begin
    list_cmd_t c;
    if (rst_n && (!in_ch.valid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        c = cmd_backlog.pop_front();
        in_ch.mode   <= c.mode;
        in_ch.handle <= c.handle;
        in_ch.value  <= c.value;
        in_ch.valid  <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern is redrawn each time phase_cycles wraps, plus one long hold-off
  always @(negedge clk) begin
    if (rst_n) begin
      phase_cycles++;
      if (phase_cycles >= 64) begin
        phase_cycles = 0;
        stall_style  = $urandom_range(0, 3);
      end
      if (!holdoff_done && in_beats >= HOLDOFF_AT) begin
        holdoff_left = HOLDOFF_CYCLES;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ch.ready <= 1'b0;
      end else begin
        case (stall_style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= 1'($urandom_range(0, 1));
          2:       out_ch.ready <= (phase_cycles % 4) != 3;
          default: out_ch.ready <= (phase_cycles % 4) == 0;
        endcase
      end
    end
  end

  // Monitor: predict on each input beat, check each result beat
  always @(posedge clk) begin : monitor
    res_t want;
    bit   in_fire;
    bit   out_fire;
    if (rst_n) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      in_taken <= in_fire;
      if (in_fire) begin
        apply_list_op(in_ch.mode, in_ch.handle, in_ch.value);
        in_beats++;
      end
      if (out_fire) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: result_value %0d", out_ch.result_value);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (out_ch.result_value !== want.result_value) begin
            $error("result_value: expected %0d, got %0d", want.result_value,
                   out_ch.result_value);
            fail_cnt++;
          end
          if (out_ch.new_handle !== want.new_handle) begin
            $error("new_handle: expected %0d, got %0d", want.new_handle, out_ch.new_handle);
            fail_cnt++;
          end
          if (out_ch.has_value !== want.has_value) begin
            $error("has_value: expected %0b, got %0b", want.has_value, out_ch.has_value);
            fail_cnt++;
          end
          if (out_ch.error !== want.error) begin
            $error("error: expected %0b, got %0b", want.error, out_ch.error);
            fail_cnt++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_ch.last);
            fail_cnt++;
          end
        end
      end
      if (in_fire || out_fire) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("doubly_linked_list_engine_unit verification failed");
        $finish;
      end
    end
  end

  initial begin
    int  base;
    bit  fill_done;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.mode    = '0;
    in_ch.handle  = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    fail_cnt      = 0;
    in_beats      = 0;
    idle_cycles   = 0;
    in_taken      = 1'b0;
    burst_left    = 0;
    gap_left      = 0;
    phase_cycles  = 0;
    stall_style   = 0;
    holdoff_left  = 0;
    holdoff_done  = 1'b0;
    gen_free      = 1;
    clear_list();

    // directed: empty list, bad handles, extremes, reuse of an erased node
    queue_cmd(MODE_DUMP, 0, 32'h0);
    queue_cmd(MODE_ERASE, 0, 32'h0);
    queue_cmd(MODE_ERASE, 1, 32'h0);
    queue_cmd(MODE_INS_AFTER, 0, 32'h7FFF_FFFF);
    queue_cmd(MODE_INS_BEFORE, 0, 32'h8000_0000);
    queue_cmd(MODE_INS_AFTER, 1, 32'hFFFF_FFFF);
    queue_cmd(MODE_INS_BEFORE, 1, 32'h0000_0000);
    queue_cmd(MODE_INS_AFTER, 5, 32'h1234_5678);
    queue_cmd(MODE_INS_BEFORE, 63, 32'h8765_4321);
    queue_cmd(MODE_DUMP, 63, 32'hFFFF_FFFF);
    queue_cmd(MODE_ERASE, 3, 32'h0);
    queue_cmd(MODE_ERASE, 3, 32'h0);
    queue_cmd(MODE_INS_AFTER, 3, 32'h5555_5555);
    queue_cmd(MODE_DUMP, 0, 32'h0);
    for (int m = MODE_CLEAR + 1; m <= MODE_TOP; m++) queue_cmd(MODE_W'(m), 42, $urandom);
    queue_cmd(MODE_ERASE, 4, 32'h0);
    queue_cmd(MODE_DUMP, 0, 32'h0);
    queue_cmd(MODE_CLEAR, 0, 32'h0);
    queue_cmd(MODE_DUMP, 0, 32'h0);
    queue_cmd(MODE_INS_BEFORE, 0, 32'hAAAA_AAAA);
    queue_cmd(MODE_DUMP, 0, 32'h0);
    queue_cmd(MODE_CLEAR, 0, 32'h0);

    base      = cmd_backlog.size();
    fill_done = 1'b0;
    while (cmd_backlog.size() - base < RANDOM_ITEMS) begin
      if (!fill_done && cmd_backlog.size() - base >= 50) begin
        gen_sequence(1'b1);
        fill_done = 1'b1;
      end else begin
        gen_sequence(1'b0);
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("doubly_linked_list_engine_unit verification clean");
    end else begin
      $display("doubly_linked_list_engine_unit verification failed");
    end
    $finish;
  end

endmodule
